/* design/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Character codes, tracker numbering, record kinds and the types shared by
// the tracker, the record sequencer and the top level.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int NUM_BRACKETS = 4;
   localparam int NUM_QUOTES   = 2;

   // Fixed widths of the result fields.
   localparam int KIND_BITS      = 2;
   localparam int ID_BITS        = 3;
   localparam int OUT_POS_BITS   = 32;
   localparam int LINE_BITS      = 24;
   localparam int COL_BITS       = 16;
   localparam int OUT_DEPTH_BITS = 16;
   localparam int OUT_COUNT_BITS = 32;

   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_TDATA_BITS = OUT_POS_BITS + LINE_BITS + COL_BITS
                                   + 2 * OUT_DEPTH_BITS + 4 * OUT_COUNT_BITS;
   localparam int RSP_TUSER_BITS = KIND_BITS + ID_BITS;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // Paren, bracket, brace, angle.
   localparam logic [7:0] OPEN_CHAR  [NUM_BRACKETS] = '{8'h28, 8'h5B, 8'h7B, 8'h3C};
   localparam logic [7:0] CLOSE_CHAR [NUM_BRACKETS] = '{8'h29, 8'h5D, 8'h7D, 8'h3E};
   // Double quote, single quote.
   localparam logic [7:0] QUOTE_CHAR [NUM_QUOTES]   = '{8'h22, 8'h27};

   localparam logic [ID_BITS-1:0] FIRST_QUOTE_ID = 3'd4;
   localparam logic [ID_BITS-1:0] LAST_TRACKER_ID = 3'd5;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_UNMATCHED = 2'd0,
      KIND_UNCLOSED  = 2'd1,
      KIND_BALANCED  = 2'd2
   } bbc_kind_type;

   // What one accepted byte asks of the record sequencer.
   typedef struct packed {
      logic       valid;
      logic       closer;
      logic [1:0] closer_id;
      logic       last;
   } bbc_ctl_type;

   typedef struct packed {
      bbc_kind_type                kind;
      logic [ID_BITS-1:0]          tracker_id;
      logic [OUT_POS_BITS-1:0]     byte_position;
      logic [LINE_BITS-1:0]        line_number;
      logic [COL_BITS-1:0]         column_number;
      logic [OUT_DEPTH_BITS-1:0]   depth_now;
      logic [OUT_DEPTH_BITS-1:0]   depth_peak;
      logic [OUT_COUNT_BITS-1:0]   opens_seen;
      logic [OUT_COUNT_BITS-1:0]   closes_seen;
      logic [OUT_COUNT_BITS-1:0]   tracker_faults;
      logic [OUT_COUNT_BITS-1:0]   all_faults;
      logic                        final_record;
   } bbc_rec_type;

endpackage

/* design/bbc_track.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker text tracker
// Holds position, line, column, bracket and quote state, and computes the
// state after each accepted byte for the record sequencer.
// ----------------------------------------------------------------------------
module bbc_track #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16,
   parameter int COUNT_BITS    = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             byte_accept,
   input  logic [7:0]                                       text_byte,
   input  logic                                             end_of_text,
   output bbc_pkg::bbc_ctl_type                             ctl,
   output logic [POSITION_BITS-1:0]                         upd_pos,
   output logic [bbc_pkg::LINE_BITS-1:0]                    upd_line,
   output logic [bbc_pkg::COL_BITS-1:0]                     upd_col,
   output logic [bbc_pkg::NUM_BRACKETS-1:0][DEPTH_BITS-1:0] upd_depth,
   output logic [bbc_pkg::NUM_BRACKETS-1:0][DEPTH_BITS-1:0] upd_peak,
   output logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_open,
   output logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_close,
   output logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_fault,
   output logic [COUNT_BITS-1:0]                            upd_total,
   output logic [bbc_pkg::NUM_QUOTES-1:0]                   upd_quote
);
   import bbc_pkg::*;

   logic [POSITION_BITS-1:0]                 pos_ff, pos_in;
   logic [LINE_BITS-1:0]                     line_ff, line_in;
   logic [COL_BITS-1:0]                      col_ff, col_in;
   logic [7:0]                               prev_ff, prev_in;
   logic [NUM_BRACKETS-1:0][DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [NUM_BRACKETS-1:0][DEPTH_BITS-1:0]  peak_ff, peak_in;
   logic [NUM_BRACKETS-1:0][COUNT_BITS-1:0]  open_ff, open_in;
   logic [NUM_BRACKETS-1:0][COUNT_BITS-1:0]  close_ff, close_in;
   logic [NUM_BRACKETS-1:0][COUNT_BITS-1:0]  fault_ff, fault_in;
   logic [COUNT_BITS-1:0]                    total_ff, total_in;
   logic [NUM_QUOTES-1:0]                    quote_ff, quote_in;

   logic                    is_newline;
   logic [NUM_BRACKETS-1:0] is_open, is_close, miss;
   logic [1:0]              closer_id;

   always_comb begin
      is_newline = (text_byte == CH_NEWLINE);
      upd_pos    = pos_ff;
      if (is_newline) begin
         upd_line = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
         upd_col  = COL_BITS'(1);
      end else begin
         upd_line = line_ff;
         upd_col  = (col_ff == '1) ? col_ff : col_ff + COL_BITS'(1);
      end

      closer_id = '0;
      for (int t = 0; t < NUM_BRACKETS; t++) begin
         is_open[t]  = (text_byte == OPEN_CHAR[t]);
         is_close[t] = (text_byte == CLOSE_CHAR[t]);
         miss[t]     = is_close[t] && (depth_ff[t] == '0);
         upd_open[t] = (is_open[t] && open_ff[t] != '1) ?
                       open_ff[t] + COUNT_BITS'(1) : open_ff[t];
         upd_close[t] = (is_close[t] && close_ff[t] != '1) ?
                        close_ff[t] + COUNT_BITS'(1) : close_ff[t];
         upd_fault[t] = (miss[t] && fault_ff[t] != '1) ?
                        fault_ff[t] + COUNT_BITS'(1) : fault_ff[t];
         if (is_open[t] && depth_ff[t] != '1) begin
            upd_depth[t] = depth_ff[t] + DEPTH_BITS'(1);
         end else if (is_close[t] && !miss[t]) begin
            upd_depth[t] = depth_ff[t] - DEPTH_BITS'(1);
         end else begin
            upd_depth[t] = depth_ff[t];
         end
         upd_peak[t] = (upd_depth[t] > peak_ff[t]) ? upd_depth[t] : peak_ff[t];
         if (miss[t]) begin
            closer_id = 2'(t);
         end
      end

      upd_total = (|miss && total_ff != '1) ? total_ff + COUNT_BITS'(1) : total_ff;

      // An escaped quote leaves its toggle alone.
      for (int q = 0; q < NUM_QUOTES; q++) begin
         upd_quote[q] = quote_ff[q] ^
                        ((text_byte == QUOTE_CHAR[q]) && (prev_ff != CH_BACKSLASH));
      end

      ctl.valid     = byte_accept && (|miss || end_of_text);
      ctl.closer    = |miss;
      ctl.closer_id = closer_id;
      ctl.last      = end_of_text;

      // The last byte of a text puts everything back to the start state.
      if (end_of_text) begin
         pos_in   = '0;
         line_in  = LINE_BITS'(1);
         col_in   = COL_BITS'(1);
         prev_in  = '0;
         depth_in = '0;
         peak_in  = '0;
         open_in  = '0;
         close_in = '0;
         fault_in = '0;
         total_in = '0;
         quote_in = '0;
      end else begin
         pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + POSITION_BITS'(1);
         line_in  = upd_line;
         col_in   = upd_col;
         prev_in  = text_byte;
         depth_in = upd_depth;
         peak_in  = upd_peak;
         open_in  = upd_open;
         close_in = upd_close;
         fault_in = upd_fault;
         total_in = upd_total;
         quote_in = upd_quote;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= COL_BITS'(1);
         prev_ff  <= '0;
         depth_ff <= '0;
         peak_ff  <= '0;
         open_ff  <= '0;
         close_ff <= '0;
         fault_ff <= '0;
         total_ff <= '0;
         quote_ff <= '0;
      end else if (byte_accept) begin
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         prev_ff  <= prev_in;
         depth_ff <= depth_in;
         peak_ff  <= peak_in;
         open_ff  <= open_in;
         close_ff <= close_in;
         fault_ff <= fault_in;
         total_ff <= total_in;
         quote_ff <= quote_in;
      end
   end

endmodule

/* design/bbc_emit.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker record sequencer
// Holds the state picture of the latest byte that produced records and
// sends its records through the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bbc_emit #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16,
   parameter int COUNT_BITS    = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  bbc_pkg::bbc_ctl_type                             ctl,
   input  logic [POSITION_BITS-1:0]                         upd_pos,
   input  logic [bbc_pkg::LINE_BITS-1:0]                    upd_line,
   input  logic [bbc_pkg::COL_BITS-1:0]                     upd_col,
   input  logic [bbc_pkg::NUM_BRACKETS-1:0][DEPTH_BITS-1:0] upd_depth,
   input  logic [bbc_pkg::NUM_BRACKETS-1:0][DEPTH_BITS-1:0] upd_peak,
   input  logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_open,
   input  logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_close,
   input  logic [bbc_pkg::NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_fault,
   input  logic [COUNT_BITS-1:0]                            upd_total,
   input  logic [bbc_pkg::NUM_QUOTES-1:0]                   upd_quote,
   input  logic                                             rec_ready,
   output logic                                             load_ready,
   output logic                                             rec_valid,
   output bbc_pkg::bbc_rec_type                             rec
);
   import bbc_pkg::*;

   // Sequencer control.
   logic               pend_closer_ff, pend_closer_in;
   logic               pend_sum_ff, pend_sum_in;
   logic [ID_BITS-1:0] sum_id_ff, sum_id_in;
   logic               out_valid_ff, out_valid_in;
   logic [COUNT_BITS-1:0] run_total_ff, run_total_in;

   // Held state picture.
   logic [1:0]                               closer_id_ff;
   logic [POSITION_BITS-1:0]                 pos_ff;
   logic [LINE_BITS-1:0]                     line_ff;
   logic [COL_BITS-1:0]                      col_ff;
   logic [NUM_BRACKETS-1:0][DEPTH_BITS-1:0]  depth_ff, peak_ff;
   logic [NUM_BRACKETS-1:0][COUNT_BITS-1:0]  open_ff, close_ff, fault_ff;
   logic [NUM_QUOTES-1:0]                    quote_ff;
   bbc_rec_type                              out_rec_ff, out_rec_in;

   logic                  bundle_valid, move, is_final, is_bracket, unclosed;
   logic [ID_BITS-1:0]    cur_id;
   logic [DEPTH_BITS-1:0] sel_depth, sel_peak;
   logic [COUNT_BITS-1:0] sel_open, sel_close, sel_fault, rec_fault, rec_total;
   bbc_rec_type           rec_in;

   always_comb begin
      bundle_valid = pend_closer_ff || pend_sum_ff;
      move         = bundle_valid && (!out_valid_ff || rec_ready);
      is_final     = pend_closer_ff ? !pend_sum_ff : (sum_id_ff == LAST_TRACKER_ID);
      load_ready   = !bundle_valid || (move && is_final);

      // The unmatched-closer record goes ahead of the end summaries.
      cur_id     = pend_closer_ff ? {1'b0, closer_id_ff} : sum_id_ff;
      is_bracket = (cur_id < FIRST_QUOTE_ID);
      if (is_bracket) begin
         sel_depth = depth_ff[cur_id[1:0]];
         sel_peak  = peak_ff[cur_id[1:0]];
         sel_open  = open_ff[cur_id[1:0]];
         sel_close = close_ff[cur_id[1:0]];
         sel_fault = fault_ff[cur_id[1:0]];
      end else begin
         sel_depth = DEPTH_BITS'(quote_ff[cur_id[0]]);
         sel_peak  = '0;
         sel_open  = '0;
         sel_close = '0;
         sel_fault = '0;
      end

      // An unclosed tracker adds its own fault, and the running total
      // carries it into the later summaries.
      unclosed  = !pend_closer_ff && (sel_depth != '0);
      rec_fault = (unclosed && sel_fault != '1) ? sel_fault + COUNT_BITS'(1) : sel_fault;
      rec_total = (unclosed && run_total_ff != '1) ?
                  run_total_ff + COUNT_BITS'(1) : run_total_ff;

      if (pend_closer_ff) begin
         rec_in.kind = KIND_UNMATCHED;
      end else if (unclosed) begin
         rec_in.kind = KIND_UNCLOSED;
      end else begin
         rec_in.kind = KIND_BALANCED;
      end
      rec_in.tracker_id     = cur_id;
      rec_in.byte_position  = OUT_POS_BITS'(pos_ff);
      rec_in.line_number    = line_ff;
      rec_in.column_number  = col_ff;
      rec_in.depth_now      = OUT_DEPTH_BITS'(sel_depth);
      rec_in.depth_peak     = OUT_DEPTH_BITS'(sel_peak);
      rec_in.opens_seen     = OUT_COUNT_BITS'(sel_open);
      rec_in.closes_seen    = OUT_COUNT_BITS'(sel_close);
      rec_in.tracker_faults = OUT_COUNT_BITS'(rec_fault);
      rec_in.all_faults     = OUT_COUNT_BITS'(rec_total);
      rec_in.final_record   = is_final;

      pend_closer_in = pend_closer_ff;
      pend_sum_in    = pend_sum_ff;
      sum_id_in      = sum_id_ff;
      run_total_in   = run_total_ff;
      if (ctl.valid) begin
         pend_closer_in = ctl.closer;
         pend_sum_in    = ctl.last;
         sum_id_in      = '0;
         run_total_in   = upd_total;
      end else if (move) begin
         run_total_in = rec_total;
         if (pend_closer_ff) begin
            pend_closer_in = 1'b0;
         end else if (sum_id_ff == LAST_TRACKER_ID) begin
            pend_sum_in = 1'b0;
         end else begin
            sum_id_in = sum_id_ff + ID_BITS'(1);
         end
      end

      if (move) begin
         out_valid_in = 1'b1;
         out_rec_in   = rec_in;
      end else begin
         out_valid_in = out_valid_ff && !rec_ready;
         out_rec_in   = out_rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_closer_ff <= 1'b0;
         pend_sum_ff    <= 1'b0;
         sum_id_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         pend_closer_ff <= pend_closer_in;
         pend_sum_ff    <= pend_sum_in;
         sum_id_ff      <= sum_id_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_total_ff <= run_total_in;
      out_rec_ff   <= out_rec_in;
      if (ctl.valid) begin
         closer_id_ff <= ctl.closer_id;
         pos_ff       <= upd_pos;
         line_ff      <= upd_line;
         col_ff       <= upd_col;
         depth_ff     <= upd_depth;
         peak_ff      <= upd_peak;
         open_ff      <= upd_open;
         close_ff     <= upd_close;
         fault_ff     <= upd_fault;
         quote_ff     <= upd_quote;
      end
   end

   assign rec_valid = out_valid_ff;
   assign rec       = out_rec_ff;

endmodule

/* design/bracket_balance_checker.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker
// Counts position, line and column of a text stream and checks the balance
// of (), [], {} and <> and of double and single quotes.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  takes one text byte per request, req_tlast on the final byte.
//   rsp_*  returns records: an unmatched-closer record right when a closer
//          arrives at depth zero, and on the final byte six summary records,
//          one per tracker in order paren, bracket, brace, angle, double
//          quote, single quote. rsp_tlast marks the last record of a byte.
//   A byte is taken every cycle while the record sequencer holds no records;
//   a byte that gives records keeps the sequencer busy until they have all
//   moved on (one, six or seven records), and the next byte is taken in the
//   cycle its last record moves to the output register.
//   A byte's records are held in the sequencer, then pass through the
//   output register. When the receiver stalls, the output register holds its
//   record and one more byte's records wait in the sequencer before
//   req_tready drops. Reset empties both and returns the counters to
//   position 0, line 1, column 1; the final byte of a text does the same.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
   parameter int POSITION_BITS = 32,
   parameter int DEPTH_BITS    = 16,
   parameter int COUNT_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bbc_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // text_byte
   input  logic                                 req_tlast,  // end_of_text
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // byte_position, line_number, column_number, depth_now, depth_peak,
   // opens_seen, closes_seen, tracker_faults, all_faults
   output logic [bbc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic [bbc_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser,  // record_kind, tracker_id
   output logic                                 rsp_tlast   // final_record
);
   import bbc_pkg::*;

   logic                                    byte_accept;
   bbc_ctl_type                             ctl;
   logic [POSITION_BITS-1:0]                upd_pos;
   logic [LINE_BITS-1:0]                    upd_line;
   logic [COL_BITS-1:0]                     upd_col;
   logic [NUM_BRACKETS-1:0][DEPTH_BITS-1:0] upd_depth, upd_peak;
   logic [NUM_BRACKETS-1:0][COUNT_BITS-1:0] upd_open, upd_close, upd_fault;
   logic [COUNT_BITS-1:0]                   upd_total;
   logic [NUM_QUOTES-1:0]                   upd_quote;
   bbc_rec_type                             rsp_rec;

   assign byte_accept = req_tvalid && req_tready;

   bbc_track #(
      .POSITION_BITS(POSITION_BITS),
      .DEPTH_BITS   (DEPTH_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .text_byte  (req_tdata),
      .end_of_text(req_tlast),
      .ctl        (ctl),
      .upd_pos    (upd_pos),
      .upd_line   (upd_line),
      .upd_col    (upd_col),
      .upd_depth  (upd_depth),
      .upd_peak   (upd_peak),
      .upd_open   (upd_open),
      .upd_close  (upd_close),
      .upd_fault  (upd_fault),
      .upd_total  (upd_total),
      .upd_quote  (upd_quote)
   );

   bbc_emit #(
      .POSITION_BITS(POSITION_BITS),
      .DEPTH_BITS   (DEPTH_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .upd_pos   (upd_pos),
      .upd_line  (upd_line),
      .upd_col   (upd_col),
      .upd_depth (upd_depth),
      .upd_peak  (upd_peak),
      .upd_open  (upd_open),
      .upd_close (upd_close),
      .upd_fault (upd_fault),
      .upd_total (upd_total),
      .upd_quote (upd_quote),
      .rec_ready (rsp_tready),
      .load_ready(req_tready),
      .rec_valid (rsp_tvalid),
      .rec       (rsp_rec)
   );

   assign rsp_tdata = {rsp_rec.all_faults, rsp_rec.tracker_faults, rsp_rec.closes_seen,
                       rsp_rec.opens_seen, rsp_rec.depth_peak, rsp_rec.depth_now,
                       rsp_rec.column_number, rsp_rec.line_number, rsp_rec.byte_position};
   assign rsp_tuser = {rsp_rec.tracker_id, rsp_rec.kind};
   assign rsp_tlast = rsp_rec.final_record;

   // A stalled input always means a record is waiting at the output next cycle.
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> rsp_tvalid)
      else $error("input stalled with no record pending");

   a_balanced_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_rec.kind == KIND_BALANCED |-> rsp_rec.depth_now == '0)
      else $error("balanced summary with nonzero depth");

   a_unmatched_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_rec.kind == KIND_UNMATCHED |->
         rsp_rec.tracker_id < FIRST_QUOTE_ID && rsp_rec.depth_now == '0)
      else $error("unmatched closer record on a quote or at nonzero depth");

   a_quote_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_rec.tracker_id == LAST_TRACKER_ID |-> rsp_rec.final_record)
      else $error("single quote summary is not the final record");

endmodule
